// ===== hdl/hssq_pkg.sv =====
// ----------------------------------------------------------------------------
// hssq_pkg
// Shared types, constants and the half-step coil table for the stepper
// sequencer.
// ----------------------------------------------------------------------------
package hssq_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned COIL_W  = 4;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned STEPS_W = CNT_W + 1;  // holds 32768
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  typedef enum logic [OP_W-1:0] {
    OP_TICK = 3'd0,
    OP_REL  = 3'd1,
    OP_ABS  = 3'd2,
    OP_OFF  = 3'd3,
    OP_HOME = 3'd4
  } op_t;

  // register byte addresses
  localparam logic [ADDR_W-1:0] ADDR_STEP_PERIOD = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_SETTLE      = 3'd4;

  localparam logic [TICK_W-1:0] STEP_PERIOD_RST = 16'd2000;
  localparam logic [TICK_W-1:0] SETTLE_RST      = 16'd1000;

  // half-step drive pattern, bit0 coil A .. bit3 coil D
  function automatic logic [COIL_W-1:0] half_step_pattern(input logic [PHASE_W-1:0] ph);
    logic [COIL_W-1:0] pat;
    case (ph)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      3'd7:    pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

// ===== hdl/hssq_if.sv =====
// ----------------------------------------------------------------------------
// hssq_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface hssq_in_if
  import hssq_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [CNT_W-1:0] step_count;
  logic signed [POS_W-1:0] target_position;

  modport source (output valid, output operation, output step_count,
                  output target_position, input ready);
  modport sink   (input valid, input operation, input step_count,
                  input target_position, output ready);
endinterface

interface hssq_out_if
  import hssq_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [COIL_W-1:0]       coils;
  logic signed [POS_W-1:0] position;
  logic                    busy_res;
  logic                    powered;
  logic                    status;

  modport source (output valid, output coils, output position, output busy_res,
                  output powered, output status, input ready);
  modport sink   (input valid, input coils, input position, input busy_res,
                  input powered, input status, output ready);
endinterface

// ===== hdl/half_step_stepper_sequencer.sv =====
// ----------------------------------------------------------------------------
// half_step_stepper_sequencer
// Four-coil unipolar stepper driver: 8-state half-step sequence, signed
// step position, settle delay and step period timing.
//
// Every command or 1 us tick transferred on in_chan yields exactly one result
// on out_chan. One item is taken per clock; it passes an input register,
// then the compute stage that updates the motor state and loads the result
// register. The state update loop closes on its own registers, so a
// transfer can follow in every cycle; in_ready only drops when both the input
// stage and the result register are full. Registers: 0x0 step period (ticks
// per half-step, 0 acts as 1), 0x4 settle time (ticks after energizing).
// Moves and home are rejected with status 1 while settling or stepping.
// ----------------------------------------------------------------------------
module half_step_stepper_sequencer
  import hssq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  hssq_in_if.sink           in_chan,
  hssq_out_if.source        out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // --- configuration registers ----------------------------------------------
  logic [TICK_W-1:0] step_period_r;
  logic [TICK_W-1:0] settle_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_period_r <= STEP_PERIOD_RST;
      settle_r      <= SETTLE_RST;
    end else if (cfg_wr) begin
      // low address bits are ignored; word index is paddr[2]
      if (paddr[2] == ADDR_STEP_PERIOD[2]) begin
        step_period_r <= pwdata[TICK_W-1:0];
      end else begin
        settle_r <= pwdata[TICK_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == ADDR_SETTLE[2]) begin
      prdata = {{(DATA_W-TICK_W){1'b0}}, settle_r};
    end else begin
      prdata = {{(DATA_W-TICK_W){1'b0}}, step_period_r};
    end
  end

  // --- input stage ----------------------------------------------------------
  logic                    s1_valid_r;
  logic [OP_W-1:0]         s1_op_r;
  logic signed [CNT_W-1:0] s1_cnt_r;
  logic signed [POS_W-1:0] s1_tgt_r;
  logic                    s1_adv;   // compute stage hands its result on
  logic                    in_xfer;
  logic                    out_valid_r;

  assign s1_adv         = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !s1_valid_r || s1_adv;
  assign in_xfer        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r  <= in_chan.operation;
      s1_cnt_r <= in_chan.step_count;
      s1_tgt_r <= in_chan.target_position;
    end
  end

  // --- motor state ----------------------------------------------------------
  logic [POS_W-1:0]   pos_r,     pos_nxt;
  logic [PHASE_W-1:0] phase_r,   phase_nxt;
  logic               coils_on_r, coils_on_nxt;
  logic [COIL_W-1:0]  pattern_r, pattern_nxt;
  logic [STEPS_W-1:0] steps_r,   steps_nxt;
  logic               reverse_r, reverse_nxt;
  logic [TICK_W-1:0]  wait_r,    wait_nxt;
  logic               status_nxt;

  // move delta: relative count, or saturated (target - position)
  logic signed [POS_W:0]   abs_diff;
  logic signed [CNT_W-1:0] delta;
  logic signed [CNT_W:0]   delta_ext;
  logic [STEPS_W-1:0]      delta_mag;
  logic                    busy;

  // tick path
  logic [TICK_W-1:0]  wait_dec;
  logic [STEPS_W-1:0] steps_dec;
  logic [PHASE_W-1:0] phase_step;
  logic [TICK_W-1:0]  period_eff;

  localparam logic signed [POS_W:0] SAT_HI = (POS_W+1)'(2**(CNT_W-1) - 1);
  localparam logic signed [POS_W:0] SAT_LO = -(POS_W+1)'(2**(CNT_W-1));

  assign busy     = (steps_r != '0) || (wait_r != '0);
  assign abs_diff = {s1_tgt_r[POS_W-1], s1_tgt_r} - $signed({pos_r[POS_W-1], pos_r});

  always_comb begin
    if (s1_op_r == OP_ABS) begin
      if (abs_diff > SAT_HI) begin
        delta = SAT_HI[CNT_W-1:0];
      end else if (abs_diff < SAT_LO) begin
        delta = SAT_LO[CNT_W-1:0];
      end else begin
        delta = abs_diff[CNT_W-1:0];
      end
    end else begin
      delta = s1_cnt_r;
    end
  end

  assign delta_ext  = {delta[CNT_W-1], delta};
  assign delta_mag  = delta_ext[CNT_W] ? STEPS_W'(-delta_ext) : STEPS_W'(delta_ext);
  assign wait_dec   = (wait_r != '0) ? wait_r - 1'b1 : wait_r;
  assign steps_dec  = steps_r - 1'b1;
  assign phase_step = reverse_r ? phase_r - 1'b1 : phase_r + 1'b1;
  assign period_eff = (step_period_r == '0) ? TICK_W'(1) : step_period_r;

  always_comb begin
    pos_nxt      = pos_r;
    phase_nxt    = phase_r;
    coils_on_nxt = coils_on_r;
    pattern_nxt  = pattern_r;
    steps_nxt    = steps_r;
    reverse_nxt  = reverse_r;
    wait_nxt     = wait_r;
    status_nxt   = 1'b0;
    case (s1_op_r)
      OP_TICK: begin
        wait_nxt = wait_dec;
        if ((wait_dec == '0) && (steps_r != '0) && coils_on_r) begin
          phase_nxt   = phase_step;
          pos_nxt     = reverse_r ? pos_r - 1'b1 : pos_r + 1'b1;
          pattern_nxt = half_step_pattern(phase_step);
          steps_nxt   = steps_dec;
          if (steps_dec != '0) begin
            wait_nxt = period_eff;
          end
        end
      end
      OP_REL, OP_ABS: begin
        if (busy) begin
          status_nxt = 1'b1;
        end else begin
          reverse_nxt = delta[CNT_W-1] || (delta == '0);
          steps_nxt   = delta_mag;
          if (!coils_on_r) begin
            coils_on_nxt = 1'b1;
            pattern_nxt  = half_step_pattern(phase_r);
            wait_nxt     = settle_r;
          end else begin
            wait_nxt = '0;
          end
        end
      end
      OP_HOME: begin
        if (busy) begin
          status_nxt = 1'b1;
        end else begin
          // coil outputs hold until the next half-step
          pos_nxt   = '0;
          phase_nxt = '0;
        end
      end
      OP_OFF: begin
        coils_on_nxt = 1'b0;
        pattern_nxt  = '0;
        steps_nxt    = '0;
        wait_nxt     = '0;
      end
      default: begin
        // unused codes: no change, status 0
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      phase_r    <= '0;
      coils_on_r <= 1'b0;
      pattern_r  <= '0;
      steps_r    <= '0;
      reverse_r  <= 1'b0;
      wait_r     <= '0;
    end else if (s1_adv) begin
      pos_r      <= pos_nxt;
      phase_r    <= phase_nxt;
      coils_on_r <= coils_on_nxt;
      pattern_r  <= pattern_nxt;
      steps_r    <= steps_nxt;
      reverse_r  <= reverse_nxt;
      wait_r     <= wait_nxt;
    end
  end

  // --- result register ------------------------------------------------------
  logic [COIL_W-1:0]  out_coils_r;
  logic [POS_W-1:0]   out_pos_r;
  logic               out_busy_r;
  logic               out_powered_r;
  logic               out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_coils_r   <= pattern_nxt;
      out_pos_r     <= pos_nxt;
      out_busy_r    <= (steps_nxt != '0) || (wait_nxt != '0);
      out_powered_r <= coils_on_nxt;
      out_status_r  <= status_nxt;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.coils    = out_coils_r;
  assign out_chan.position = out_pos_r;
  assign out_chan.busy_res = out_busy_r;
  assign out_chan.powered  = out_powered_r;
  assign out_chan.status   = out_status_r;

`ifndef ASSERT_OFF
  // a rejected command leaves the block busy
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.status |-> out_chan.busy_res)
    else $error("rejected command reported while idle");

  // coils are dark whenever they are not energized
  a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
    !coils_on_r |-> (pattern_r == '0))
    else $error("coil pattern set while de-energized");

  // pending steps only with energized coils
  a_steps_powered: assert property (@(posedge clk) disable iff (!rst_n)
    (steps_r != '0) |-> coils_on_r)
    else $error("steps pending with coils off");

  // step count never exceeds one full 16-bit magnitude
  a_steps_range: assert property (@(posedge clk) disable iff (!rst_n)
    (steps_r <= STEPS_W'(2**(CNT_W-1))))
    else $error("step count out of range");

  // a result handed on by the compute stage always lands in the result register
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("result lost after compute stage");
`endif

endmodule

// ===== test/hssq_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hssq_result_checker
// Watches the command, result and register channels of the stepper
// sequencer, keeps its own copy of the motor state and checks every result
// transfer, field by field, against the oldest expected result.
// ----------------------------------------------------------------------------
module hssq_result_checker
  import hssq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  hssq_in_if                in_mon,
  hssq_out_if               out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic [DATA_W-1:0] prdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending_results,
  output int                results_seen,
  output int                rejected_cmds,
  output int                half_steps
);

  typedef struct packed {
    logic [COIL_W-1:0]       coils;
    logic signed [POS_W-1:0] position;
    logic                    busy;
    logic                    powered;
    logic                    status;
  } motor_result_t;

  localparam logic [COIL_W-1:0] COIL_DRIVE [8] = '{
    4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
  };
  localparam longint DELTA_MAX = 32767;
  localparam longint DELTA_MIN = -32768;

  // timing registers
  logic [TICK_W-1:0] period_cfg;
  logic [TICK_W-1:0] settle_cfg;

  // motor state
  logic signed [POS_W-1:0] pos_q;
  logic [PHASE_W-1:0]      phase_q;
  logic                    energized;
  logic [COIL_W-1:0]       drive_q;
  int                      steps_left;
  logic                    reverse;
  int                      wait_ticks;

  motor_result_t expected_results[$];
  int errors;
  int seen;
  int rejects;
  int steps_done;

  function automatic logic motor_busy();
    return (steps_left != 0) || (wait_ticks != 0);
  endfunction

  task automatic begin_move(input int delta);
    reverse    = (delta <= 0);
    steps_left = (delta >= 0) ? delta : -delta;
    if (!energized) begin
      energized  = 1'b1;
      drive_q    = COIL_DRIVE[phase_q];
      wait_ticks = int'(settle_cfg);
    end else begin
      wait_ticks = 0;
    end
  endtask

  task automatic advance_tick();
    if (wait_ticks != 0)
      wait_ticks--;
    if (wait_ticks == 0 && steps_left != 0 && energized) begin
      if (reverse) begin
        phase_q = phase_q - 1'b1;
        pos_q   = pos_q - 1;
      end else begin
        phase_q = phase_q + 1'b1;
        pos_q   = pos_q + 1;
      end
      drive_q = COIL_DRIVE[phase_q];
      steps_left--;
      steps_done++;
      // a zero period behaves as one tick
      if (steps_left != 0)
        wait_ticks = (period_cfg == '0) ? 1 : int'(period_cfg);
    end
  endtask

  task automatic apply_item(input logic [OP_W-1:0] op, input logic signed [CNT_W-1:0] cnt,
                            input logic signed [POS_W-1:0] tgt, output motor_result_t res);
    longint delta;
    logic   rejected;
    rejected = 1'b0;
    case (op)
      OP_TICK: advance_tick();
      OP_REL, OP_ABS, OP_HOME: begin
        if (motor_busy()) begin
          rejected = 1'b1;
          rejects++;
        end else if (op == OP_REL) begin
          begin_move(int'(cnt));
        end else if (op == OP_ABS) begin
          delta = longint'(tgt) - longint'(pos_q);
          if (delta > DELTA_MAX) delta = DELTA_MAX;
          if (delta < DELTA_MIN) delta = DELTA_MIN;
          begin_move(int'(delta));
        end else begin
          // coils keep their pattern until the next half-step
          pos_q   = '0;
          phase_q = '0;
        end
      end
      OP_OFF: begin
        energized  = 1'b0;
        drive_q    = '0;
        steps_left = 0;
        wait_ticks = 0;
      end
      default: ;
    endcase
    res.coils    = drive_q;
    res.position = pos_q;
    res.busy     = motor_busy();
    res.powered  = energized;
    res.status   = rejected;
  endtask

  always @(posedge clk) begin
    motor_result_t got;
    motor_result_t want;
    if (!rst_n) begin
      period_cfg = STEP_PERIOD_RST;
      settle_cfg = SETTLE_RST;
      pos_q      = '0;
      phase_q    = '0;
      energized  = 1'b0;
      drive_q    = '0;
      steps_left = 0;
      reverse    = 1'b0;
      wait_ticks = 0;
      expected_results.delete();
    end else begin
      // results first: a result never belongs to a command taken at this edge
      if (out_mon.valid && out_mon.ready) begin
        seen++;
        got = '{coils: out_mon.coils, position: out_mon.position, busy: out_mon.busy_res,
                powered: out_mon.powered, status: out_mon.status};
        if (expected_results.size() == 0) begin
          $error("result transfer with no command outstanding");
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.coils !== want.coils) begin
            $error("coils: expected %h, actual %h", want.coils, got.coils);
            errors++;
          end
          if (got.position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, got.position);
            errors++;
          end
          if (got.busy !== want.busy) begin
            $error("busy_res: expected %b, actual %b", want.busy, got.busy);
            errors++;
          end
          if (got.powered !== want.powered) begin
            $error("powered: expected %b, actual %b", want.powered, got.powered);
            errors++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %b, actual %b", want.status, got.status);
            errors++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        apply_item(in_mon.operation, in_mon.step_count, in_mon.target_position, want);
        expected_results.push_back(want);
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == ADDR_STEP_PERIOD)
            period_cfg = pwdata[TICK_W-1:0];
          else if (paddr == ADDR_SETTLE)
            settle_cfg = pwdata[TICK_W-1:0];
        end else if (paddr == ADDR_STEP_PERIOD && prdata[TICK_W-1:0] !== period_cfg) begin
          $error("step_period_ticks: expected %0d, actual %0d", period_cfg,
                 prdata[TICK_W-1:0]);
          errors++;
        end else if (paddr == ADDR_SETTLE && prdata[TICK_W-1:0] !== settle_cfg) begin
          $error("settle_ticks: expected %0d, actual %0d", settle_cfg, prdata[TICK_W-1:0]);
          errors++;
        end
      end
    end
    fail_count      <= errors;
    pending_results <= expected_results.size();
    results_seen    <= seen;
    rejected_cmds   <= rejects;
    half_steps      <= steps_done;
  end

  initial begin
    errors     = 0;
    seen       = 0;
    rejects    = 0;
    steps_done = 0;
  end

endmodule

// ===== test/half_step_stepper_sequencer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_step_stepper_sequencer_tb
// Drives ticks and move/home/de-energize commands into the stepper sequencer
// under several step period and settle time settings, with random gaps on
// both channels; the checker predicts each result and counts mismatches.
// ----------------------------------------------------------------------------
module half_step_stepper_sequencer_tb;
  import hssq_pkg::*;

  // bound for the slowest legal run: ~2100 transfers, each with a random gap and stall
  localparam int unsigned CYCLE_LIMIT     = 400_000;
  localparam int          RANDOM_PHASES   = 8;
  localparam int          ITEMS_PER_PHASE = 250;
  localparam int          EXTREME_ITEMS   = 20;
  localparam int          TAIL_CYCLES     = 8;

  // operation codes the block ignores
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam logic [TICK_W-1:0] TICKS_MAX = '1;

  logic clk = 1'b0;
  logic rst_n;

  // register port
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  hssq_in_if  in_chan ();
  hssq_out_if out_chan ();

  int          fail_count;
  int          pending_results;
  int          results_seen;
  int          rejected_cmds;
  int          half_steps;
  int unsigned cycle_count = 0;
  int          transfers_sent = 0;
  int          timing_settings = 0;
  bit          send_idle = 1'b1;
  bit          take_idle = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  half_step_stepper_sequencer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  hssq_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .results_seen    (results_seen),
    .rejected_cmds   (rejected_cmds),
    .half_steps      (half_steps)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("half_step_stepper_sequencer test failed");
      $finish;
    end
  end

  // result side: random stall before each transfer, with stretches of none
  initial begin : result_taker
    int stall;
    out_chan.ready <= 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0)
        take_idle = !take_idle;
      stall = take_idle ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_chan.valid));
    end
  end

  // one command or tick transfer; valid stays up across back-to-back transfers
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [CNT_W-1:0] cnt,
                          input logic [POS_W-1:0] tgt);
    int gap;
    if ($urandom_range(0, 39) == 0)
      send_idle = !send_idle;
    gap = send_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid           <= 1'b1;
    in_chan.operation       <= op;
    in_chan.step_count      <= cnt;
    in_chan.target_position <= tgt;
    do @(posedge clk); while (!in_chan.ready);
    transfers_sent++;
  endtask

  // ticks carry junk in the unused fields
  task automatic send_ticks(input int n);
    repeat (n) send_cmd(OP_TICK, CNT_W'($urandom), $urandom);
  endtask

  // stop sending and wait until every result is back
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // setup then access phase; the caller drops psel after the last access
  task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // registers only change while nothing is in flight; read back after writing
  task automatic set_timing(input logic [TICK_W-1:0] period, input logic [TICK_W-1:0] settle);
    drain_results();
    apb_access(1'b1, ADDR_STEP_PERIOD, DATA_W'(period));
    apb_access(1'b1, ADDR_SETTLE, DATA_W'(settle));
    apb_access(1'b0, ADDR_STEP_PERIOD, '0);
    apb_access(1'b0, ADDR_SETTLE, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
    timing_settings++;
  endtask

  // Random traffic: mostly ticks so moves run to completion, small moves near
  // home, now and then a full-range count or target, aborts, homes, spare codes.
  task automatic send_random_cmd();
    int                roll;
    logic [CNT_W-1:0]  cnt;
    logic [POS_W-1:0]  tgt;
    roll = $urandom_range(0, 99);
    cnt  = CNT_W'($urandom);
    tgt  = $urandom;
    if (roll < 65) begin
      send_cmd(OP_TICK, cnt, tgt);
    end else if (roll < 77) begin
      if ($urandom_range(0, 7) != 0)
        cnt = CNT_W'(int'($urandom_range(0, 16)) - 8);
      send_cmd(OP_REL, cnt, tgt);
    end else if (roll < 85) begin
      if ($urandom_range(0, 7) != 0)
        tgt = POS_W'(int'($urandom_range(0, 80)) - 40);
      send_cmd(OP_ABS, cnt, tgt);
    end else if (roll < 89) begin
      send_cmd(OP_OFF, cnt, tgt);
    end else if (roll < 94) begin
      send_cmd(OP_HOME, cnt, tgt);
    end else if (roll < 97) begin
      send_cmd(OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), cnt, tgt);
    end else begin
      send_cmd(OP_TICK, cnt, tgt);
    end
  endtask

  initial begin : stimulus
    int ph;
    rst_n                   <= 1'b0;
    in_chan.valid           <= 1'b0;
    in_chan.operation       <= OP_TICK;
    in_chan.step_count      <= '0;
    in_chan.target_position <= '0;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: reset timing (period 2000, settle 1000) ---
    send_ticks(1);                                         // idle tick, coils off
    send_cmd(OP_SPARE_LO, 16'h7FFF, 32'h7FFF_FFFF);        // ignored codes
    send_cmd(OP_SPARE_LO + 3'd1, 16'h8000, 32'h8000_0000);
    send_cmd(OP_SPARE_HI, 16'hFFFF, 32'hFFFF_FFFF);
    send_cmd(OP_HOME, '0, '0);                             // home while unpowered
    send_cmd(OP_REL, 16'd5, '0);                           // energize, start settling
    send_cmd(OP_REL, 16'hFFFF, '0);                        // busy: rejected
    send_cmd(OP_ABS, '0, 32'd100);                         // busy: rejected
    send_cmd(OP_HOME, '0, '0);                             // busy: rejected
    send_ticks(1);
    send_cmd(OP_OFF, '0, '0);                              // abort while settling

    // --- directed: short timing ---
    set_timing(16'd1, 16'd2);
    send_cmd(OP_REL, '0, '0);                              // zero move from off: settles
    send_ticks(2);
    send_cmd(OP_REL, '0, '0);                              // zero move while on: no-op
    send_cmd(OP_REL, 16'd3, '0);
    send_ticks(3);
    send_cmd(OP_HOME, '0, '0);                             // home keeps coil pattern
    send_cmd(OP_REL, 16'h8000, '0);                        // most negative count
    send_ticks(2);
    send_cmd(OP_OFF, '0, '0);
    send_cmd(OP_ABS, '0, 32'h7FFF_FFFF);                   // delta saturates high
    send_ticks(1);
    send_cmd(OP_OFF, '0, '0);
    send_cmd(OP_ABS, '0, 32'h8000_0000);                   // delta saturates low
    send_cmd(OP_OFF, '0, '0);

    // --- random phases: zero period and zero settle first, then small random ---
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_timing((ph == 0) ? TICK_W'(0) : TICK_W'($urandom_range(1, 5)),
                 (ph == 1) ? TICK_W'(0) : TICK_W'($urandom_range(0, 6)));
      repeat (ITEMS_PER_PHASE) send_random_cmd();
    end

    // --- longest timing: waits count down from the top; multi-step moves never finish ---
    set_timing(TICKS_MAX, TICKS_MAX);
    repeat (EXTREME_ITEMS) send_random_cmd();
    set_timing(TICKS_MAX, '0);
    repeat (EXTREME_ITEMS) send_random_cmd();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d transfers over %0d timing settings, checked %0d results.",
             transfers_sent, timing_settings, results_seen);
    $display("Model took %0d half-steps and rejected %0d busy commands.",
             half_steps, rejected_cmds);
    if (fail_count == 0) begin
      $display("half_step_stepper_sequencer test passed");
    end else begin
      $display("half_step_stepper_sequencer test failed");
    end
    $finish;
  end

endmodule
